FILE: design/qeas_pkg.sv
// ----------------------------------------------------------------------------
// Encoder angle and speed estimator package
// Shared widths, register indexes, request types and small helper functions.
// ----------------------------------------------------------------------------
package qeas_pkg;

	// Position counter width and angle resolution.
	localparam int CNT_BITS   = 32;
	localparam int ANGLE_BITS = 16;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_MODE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_COUNT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_GAIN  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_POLE_PAIRS  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ELEC_OFFSET = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_GAIN  = 3'd5;

	localparam logic signed [40:0] S32_MAX = 41'sd2147483647;
	localparam logic signed [40:0] S32_MIN = -41'sd2147483648;

	typedef struct packed {
		logic        unit_event;
		logic [31:0] pos_count;
		logic [31:0] unit_timer;
		logic [15:0] capture_latch;
		logic        overflow_flag;
		logic        underflow_flag;
		logic        capture_error;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] mech_angle;
		logic signed [15:0] elec_angle;
		logic signed [31:0] mech_speed;
		logic signed [31:0] elec_speed;
		logic signed [31:0] accel_diff;
		logic signed [31:0] jerk_diff;
		logic        [15:0] wrap_errors;
	} result_t;

	// Top ANGLE_BITS of a turn fraction as a signed angle, returned in 16 bits.
	function automatic logic signed [15:0] angle_out(input logic [31:0] frac);
		logic [ANGLE_BITS-1:0] v;
		logic signed [31:0]    ext;
		v   = frac[31 -: ANGLE_BITS];
		ext = 32'(signed'(v));
		return ext[15:0];
	endfunction

	// Saturate a signed value to the 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = signed'(v[31:0]);
		end
		return r;
	endfunction

endpackage

FILE: design/encoder_angle_speed_estimator.sv
// ----------------------------------------------------------------------------
// Encoder angle and speed estimator
// Turns quadrature counter samples into angles and M/T or difference speed.
// ----------------------------------------------------------------------------
// One sample request yields one result request. After acceptance a sample
// passes through the event update, the operand setup, the bit-serial
// multiplier (speed gain and angle gain are scanned one bit per cycle),
// the divider seed, the restoring divider (one quotient bit per cycle),
// the states that form the signed speeds, the electrical angle and the
// linear-mode differences, the final state that loads the output register
// and the idle state in which the next sample is taken. The result sits in
// an output register, so a new sample is accepted while an earlier result
// still waits; the block only stalls at the end of a sample if that register
// is still full. Configuration registers are written through a plain write
// port and should only be changed while idle.
// Rotary mode gives delta * speed_gain / ((timer - capture) * 65536), zero
// when the timer difference is zero; linear mode divides by 65536 alone and
// also reports raw per-sample differences of electrical speed and
// acceleration.
// ----------------------------------------------------------------------------
module encoder_angle_speed_estimator
	import qeas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Sample channel
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  sample_t                  sample,
	// Result channel
	output logic                     result_valid,
	input  logic                     result_ready,
	output result_t                  result,
	// Configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EVT  = 4'd1;
	localparam logic [3:0] ST_PREP = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_DVI  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_MECH = 4'd6;
	localparam logic [3:0] ST_ELEC = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	localparam logic [5:0] MUL_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'd39;

	// Configuration registers.
	logic        motor_mode_q;
	logic [31:0] max_count_q;
	logic [31:0] angle_gain_q;
	logic [6:0]  pole_pairs_q;
	logic [15:0] elec_offset_q;
	logic [31:0] speed_gain_q;

	// Estimator history.
	logic               [31:0] latched_count_q;
	logic               [31:0] previous_count_q;
	logic signed        [33:0] count_delta_q;
	logic               [15:0] latched_capture_q;
	logic signed        [31:0] prev_elec_q;
	logic signed        [31:0] prev_accel_q;
	logic               [15:0] error_tally_q;

	// Sequencer and datapath registers.
	logic [3:0]         state_q;
	logic [5:0]         step_q;
	sample_t            smp_q;
	logic               neg_q;
	logic               zero_q;
	logic               sat_q;
	logic [33:0]        mag_q;
	logic [47:0]        dvsr_q;
	logic [31:0]        sgain_sr_q;
	logic [31:0]        again_sr_q;
	logic [65:0]        prod_q;
	logic [31:0]        frac_q;
	logic [47:0]        rem_q;
	logic [39:0]        num_sr_q;
	logic [39:0]        quo_q;
	logic signed [31:0] mech_q;
	logic signed [31:0] elec_q;
	logic [31:0]        efrac_q;
	logic signed [31:0] accel_q;
	logic               result_valid_q;
	result_t            result_q;

	// Combinational helpers.
	logic [31:0]        cnt;
	logic [31:0]        maxc;
	logic signed [33:0] span;
	logic signed [33:0] raw_delta;
	logic signed [33:0] new_delta;
	logic               tally_inc;
	logic signed [33:0] sel_delta;
	logic [31:0]        dt;
	logic [48:0]        trial;
	logic               trial_ge;
	logic signed [31:0] mech_c;
	logic signed [39:0] elec_prod;
	logic signed [32:0] accel_wide;
	logic signed [32:0] jerk_wide;
	logic signed [31:0] jerk_c;
	logic               out_free;

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	// Event update: wrap-corrected count delta, with wrap errors counted when
	// the counter sits exactly on its limit, and a zero delta on a capture error.
	always_comb begin
		cnt       = 32'(smp_q.pos_count[CNT_BITS-1:0]);
		maxc      = 32'(max_count_q[CNT_BITS-1:0]);
		span      = signed'({2'b00, maxc}) + 34'sd1;
		raw_delta = signed'({2'b00, cnt}) - signed'({2'b00, previous_count_q});
		new_delta = raw_delta;
		tally_inc = 1'b0;
		if (smp_q.overflow_flag) begin
			if (cnt == maxc) begin
				tally_inc = 1'b1;
			end else begin
				new_delta = raw_delta + span;
			end
		end else if (smp_q.underflow_flag) begin
			if (cnt == 32'd0) begin
				tally_inc = 1'b1;
			end else begin
				new_delta = raw_delta - span;
			end
		end
		if (smp_q.capture_error) begin
			new_delta = '0;
		end
	end

	// Operand selection: linear mode uses this sample's delta over a divisor of
	// one, rotary mode the held delta over the timer difference.
	always_comb begin
		if (motor_mode_q) begin
			sel_delta = smp_q.unit_event ? count_delta_q : '0;
			dt        = 32'd1;
		end else begin
			sel_delta = count_delta_q;
			dt        = smp_q.unit_timer - {16'h0000, latched_capture_q};
		end
	end

	// One restoring division step.
	always_comb begin
		trial    = {rem_q, num_sr_q[39]};
		trial_ge = (trial >= {1'b0, dvsr_q});
	end

	// Sign and saturate the quotient.
	always_comb begin
		if (zero_q) begin
			mech_c = '0;
		end else if (!neg_q) begin
			mech_c = (sat_q || (quo_q[39:31] != '0)) ? 32'sh7FFF_FFFF
			                                         : signed'(quo_q[31:0]);
		end else if (sat_q || (quo_q > 40'h00_8000_0000)) begin
			mech_c = 32'sh8000_0000;
		end else begin
			mech_c = signed'(32'd0 - quo_q[31:0]);
		end
	end

	always_comb begin
		elec_prod  = $signed({1'b0, pole_pairs_q}) * mech_q;
		accel_wide = 33'(elec_q) - 33'(prev_elec_q);
		jerk_wide  = 33'(accel_q) - 33'(prev_accel_q);
		jerk_c     = motor_mode_q ? sat32(41'(jerk_wide)) : '0;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_mode_q  <= 1'b0;
			max_count_q   <= 32'd4095;
			angle_gain_q  <= 32'd1048576;
			pole_pairs_q  <= 7'd4;
			elec_offset_q <= 16'd0;
			speed_gain_q  <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOTOR_MODE:  motor_mode_q  <= cfg_wdata[0];
				REG_MAX_COUNT:   max_count_q   <= cfg_wdata[31:0];
				REG_ANGLE_GAIN:  angle_gain_q  <= cfg_wdata[31:0];
				REG_POLE_PAIRS:  pole_pairs_q  <= cfg_wdata[6:0];
				REG_ELEC_OFFSET: elec_offset_q <= cfg_wdata[15:0];
				REG_SPEED_GAIN:  speed_gain_q  <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// Sequencer, history and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			step_q            <= '0;
			latched_count_q   <= '0;
			previous_count_q  <= '0;
			count_delta_q     <= '0;
			latched_capture_q <= '0;
			prev_elec_q       <= '0;
			prev_accel_q      <= '0;
			error_tally_q     <= '0;
			result_valid_q    <= 1'b0;
		end else begin
			// The final state reloads the output register itself.
			if (result_valid_q && result_ready && (state_q != ST_FIN)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_EVT;
					end
				end
				ST_EVT: begin
					if (smp_q.unit_event) begin
						latched_count_q   <= cnt;
						latched_capture_q <= smp_q.capture_latch;
						previous_count_q  <= cnt;
						count_delta_q     <= new_delta;
						if (tally_inc && (error_tally_q != 16'hFFFF)) begin
							error_tally_q <= error_tally_q + 16'd1;
						end
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					step_q  <= MUL_LAST;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q - 6'd1;
					if (step_q == '0) begin
						state_q <= ST_DVI;
					end
				end
				ST_DVI: begin
					step_q  <= DIV_LAST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - 6'd1;
					if (step_q == '0) begin
						state_q <= ST_MECH;
					end
				end
				ST_MECH: state_q <= ST_ELEC;
				ST_ELEC: state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						if (motor_mode_q) begin
							prev_elec_q  <= elec_q;
							prev_accel_q <= accel_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					smp_q <= sample;
				end
			end
			ST_PREP: begin
				// Magnitude and sign of the delta, divisor scaled by 65536.
				neg_q      <= sel_delta[33];
				mag_q      <= sel_delta[33] ? unsigned'(-sel_delta) : unsigned'(sel_delta);
				zero_q     <= (dt == 32'd0);
				dvsr_q     <= {dt, 16'h0000};
				sgain_sr_q <= speed_gain_q;
				again_sr_q <= angle_gain_q;
				prod_q     <= '0;
				frac_q     <= '0;
			end
			ST_MUL: begin
				// MSB-first shift and add, one gain bit per cycle.
				prod_q     <= {prod_q[64:0], 1'b0} + (sgain_sr_q[31] ? 66'(mag_q) : 66'd0);
				frac_q     <= {frac_q[30:0], 1'b0} + (again_sr_q[31] ? latched_count_q : 32'd0);
				sgain_sr_q <= {sgain_sr_q[30:0], 1'b0};
				again_sr_q <= {again_sr_q[30:0], 1'b0};
			end
			ST_DVI: begin
				// Any quotient bit above bit 39 means the result saturates; else
				// the upper product bits seed the remainder directly.
				sat_q    <= ({22'd0, prod_q[65:40]} >= dvsr_q);
				rem_q    <= 48'(prod_q[65:40]);
				num_sr_q <= prod_q[39:0];
				quo_q    <= '0;
			end
			ST_DIV: begin
				rem_q    <= trial_ge ? 48'(trial - {1'b0, dvsr_q}) : trial[47:0];
				quo_q    <= {quo_q[38:0], trial_ge};
				num_sr_q <= {num_sr_q[38:0], 1'b0};
			end
			ST_MECH: begin
				mech_q <= mech_c;
			end
			ST_ELEC: begin
				elec_q  <= sat32(41'(elec_prod));
				efrac_q <= 32'(32'(pole_pairs_q) * frac_q) + {elec_offset_q, 16'h0000};
			end
			ST_ACC: begin
				accel_q <= motor_mode_q ? sat32(41'(accel_wide)) : '0;
			end
			ST_FIN: begin
				if (out_free) begin
					result_q.mech_angle  <= angle_out(frac_q);
					result_q.elec_angle  <= angle_out(efrac_q);
					result_q.mech_speed  <= mech_q;
					result_q.elec_speed  <= elec_q;
					result_q.accel_diff  <= accel_q;
					result_q.jerk_diff   <= jerk_c;
					result_q.wrap_errors <= error_tally_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/sv/encoder_angle_speed_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle and speed estimator testbench
// Feeds counter samples through the valid/ready sample channel and compares
// every result request, field by field, with a cycle-free estimate that is
// computed in order when each sample request is accepted.
// ----------------------------------------------------------------------------
module encoder_angle_speed_estimator_tb;
	import qeas_pkg::*;

	// Motor mode codes as written to the mode register.
	localparam logic MODE_ROTARY = 1'b0;
	localparam logic MODE_LINEAR = 1'b1;

	// Processing every sample plus bursts of idling on both sides stays far below
	// this bound, even for a few hundred samples and a long output stall.
	localparam int CYCLE_LIMIT = 400000;

	// Cycles allowed after the last result for stray results to show up.
	localparam int SETTLE_CYCLES = 100;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	sample_t                  sample = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	result_t                  result;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	encoder_angle_speed_estimator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Mirror of the configuration registers, starting from their reset values.
	// ------------------------------------------------------------------------
	logic        m_mode        = MODE_ROTARY;
	logic [31:0] m_max_count   = 32'd4095;
	logic [31:0] m_angle_gain  = 32'd1048576;
	logic [6:0]  m_pole_pairs  = 7'd4;
	logic [15:0] m_elec_offset = 16'd0;
	logic [31:0] m_speed_gain  = 32'd65536;

	// Estimator state: the count and capture held from the last unit event,
	// the wrap-corrected count delta, the linear-mode history and the tally of
	// wrap flags that arrived with the count sitting on its limit.
	logic [31:0]        held_count      = '0;
	logic [31:0]        last_count      = '0;
	longint             held_delta      = 0;
	logic [15:0]        held_capture    = '0;
	logic signed [31:0] last_elec_speed = '0;
	logic signed [31:0] last_accel      = '0;
	logic [15:0]        wrap_tally      = '0;

	// Results that are owed by the block, oldest first.
	result_t due_estimates[$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  gaps_on        = 1'b1;
	int  sink_stall     = 0;
	int  sink_hold_req  = 0;

	// Position of the simulated encoder used to build well-formed samples.
	longint enc_pos = 0;

	// ------------------------------------------------------------------------
	// Estimate arithmetic
	// ------------------------------------------------------------------------
	function automatic logic signed [31:0] clamp_s32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return 32'(v);
	endfunction

	// Magnitude of delta times gain over divisor*65536, truncated toward zero,
	// then given the sign of delta and clamped to 32 bits. The product needs
	// up to 65 bits, so the whole division is done at 66 bits.
	function automatic logic signed [31:0] scaled_speed(input longint delta,
			input logic [31:0] gain, input logic [31:0] divisor);
		logic        neg;
		logic [65:0] mag, num, den, quo;
		neg = (delta < 0);
		mag = neg ? 66'(-delta) : 66'(delta);
		num = mag * {34'd0, gain};
		den = {18'd0, divisor, 16'd0};
		quo = num / den;
		if (!neg) begin
			return (quo > 66'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quo[31:0]);
		end
		return (quo > 66'h0_8000_0000) ? 32'sh8000_0000 : 32'(32'd0 - quo[31:0]);
	endfunction

	// Advances the estimator state by one accepted sample and returns the
	// result that the block owes for it.
	function automatic result_t estimate_angle_speed(input sample_t s);
		result_t            r;
		longint             d, lim;
		logic [63:0]        prod;
		logic [31:0]        frac, efrac, dt;
		logic signed [31:0] mech, elec, accel, jerk;
		accel = '0;
		jerk  = '0;
		if (s.unit_event) begin
			lim          = longint'(m_max_count) + 1;
			d            = longint'(s.pos_count) - longint'(last_count);
			held_count   = s.pos_count;
			held_capture = s.capture_latch;
			// Overflow wins over underflow. A wrap flag with the count on the
			// limit itself is counted as an error and left uncorrected.
			if (s.overflow_flag) begin
				if (s.pos_count == m_max_count) begin
					if (wrap_tally != 16'hFFFF) wrap_tally++;
				end else begin
					d += lim;
				end
			end else if (s.underflow_flag) begin
				if (s.pos_count == 32'd0) begin
					if (wrap_tally != 16'hFFFF) wrap_tally++;
				end else begin
					d -= lim;
				end
			end
			last_count = s.pos_count;
			if (s.capture_error) d = 0;
			held_delta = d;
		end

		prod  = 64'(held_count) * 64'(m_angle_gain);
		frac  = prod[31:0];
		prod  = 64'(m_pole_pairs) * 64'(frac) + (64'(m_elec_offset) << 16);
		efrac = prod[31:0];

		if (m_mode == MODE_ROTARY) begin
			dt   = s.unit_timer - {16'd0, held_capture};
			mech = (dt != 32'd0) ? scaled_speed(held_delta, m_speed_gain, dt) : '0;
			elec = clamp_s32(longint'(m_pole_pairs) * longint'(mech));
		end else begin
			mech  = scaled_speed(s.unit_event ? held_delta : 0, m_speed_gain, 32'd1);
			elec  = clamp_s32(longint'(m_pole_pairs) * longint'(mech));
			accel = clamp_s32(longint'(elec) - longint'(last_elec_speed));
			jerk  = clamp_s32(longint'(accel) - longint'(last_accel));
			last_elec_speed = elec;
			last_accel      = accel;
		end

		r.mech_angle  = frac[31:16];
		r.elec_angle  = efrac[31:16];
		r.mech_speed  = mech;
		r.elec_speed  = elec;
		r.accel_diff  = accel;
		r.jerk_diff   = jerk;
		r.wrap_errors = wrap_tally;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic sample_t mk_sample(input logic ev, input logic [31:0] cnt,
			input logic [31:0] tmr, input logic [15:0] cap,
			input logic ovf, input logic unf, input logic cerr);
		sample_t s;
		s.unit_event     = ev;
		s.pos_count      = cnt;
		s.unit_timer     = tmr;
		s.capture_latch  = cap;
		s.overflow_flag  = ovf;
		s.underflow_flag = unf;
		s.capture_error  = cerr;
		return s;
	endfunction

	// Most samples follow a plausible encoder: small steps around the current
	// position with the wrap flag set when the count rolls over, and a timer a
	// little past the capture. The rest are pure noise, counts parked on the
	// limit with a wrap flag, and captures equal to the timer.
	function automatic sample_t random_sample();
		sample_t     s;
		longint      lim, span, np;
		int          pick;
		logic [15:0] base;
		pick             = $urandom_range(0, 15);
		s.unit_event     = 1'($urandom_range(0, 1));
		s.pos_count      = $urandom;
		s.unit_timer     = $urandom;
		s.capture_latch  = 16'($urandom);
		s.overflow_flag  = 1'($urandom_range(0, 1));
		s.underflow_flag = 1'($urandom_range(0, 1));
		s.capture_error  = 1'($urandom_range(0, 1));
		if (pick == 0) return s;

		lim = longint'(m_max_count) + 1;
		if (enc_pos > lim - 1) enc_pos = 0;
		span = (lim - 1 < 40) ? lim - 1 : 40;
		np   = enc_pos + longint'($urandom_range(0, 32'(2 * span))) - span;
		s.overflow_flag  = 1'b0;
		s.underflow_flag = 1'b0;
		s.capture_error  = ($urandom_range(0, 15) == 0);
		if (np > lim - 1) begin
			np -= lim;
			s.overflow_flag = 1'b1;
		end else if (np < 0) begin
			np += lim;
			s.underflow_flag = 1'b1;
		end
		s.unit_event = (pick >= 2 && pick <= 12);
		case (pick)
			2: begin
				np = lim - 1;
				s.overflow_flag = 1'b1;
			end
			3: begin
				np = 0;
				s.underflow_flag = 1'b1;
			end
			default: ;
		endcase
		s.pos_count = 32'(np);
		if (s.unit_event) enc_pos = np;
		base = s.unit_event ? s.capture_latch : held_capture;
		s.unit_timer = {16'd0, base} + ((pick == 4) ? 32'd0 : 32'($urandom_range(0, 4000)));
		return s;
	endfunction

	// Offers one sample request and waits until it is accepted. Valid is only
	// lowered ahead of a gap, so back-to-back requests keep it high.
	task automatic offer_sample(input sample_t s);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		due_estimates.push_back(estimate_angle_speed(s));
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (due_estimates.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Writes all six registers while the block is idle and updates the mirror.
	task automatic apply_settings(input logic [31:0] mode, input logic [31:0] max_cnt,
			input logic [31:0] a_gain, input logic [31:0] pp,
			input logic [31:0] e_off, input logic [31:0] s_gain);
		put_reg(REG_MOTOR_MODE, mode);
		put_reg(REG_MAX_COUNT, max_cnt);
		put_reg(REG_ANGLE_GAIN, a_gain);
		put_reg(REG_POLE_PAIRS, pp);
		put_reg(REG_ELEC_OFFSET, e_off);
		put_reg(REG_SPEED_GAIN, s_gain);
		cfg_we <= 1'b0;
		m_mode        = mode[0];
		m_max_count   = max_cnt;
		m_angle_gain  = a_gain;
		m_pole_pairs  = pp[6:0];
		m_elec_offset = e_off[15:0];
		m_speed_gain  = s_gain;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset values of the registers, rotary mode: a plain event, a sample
	// without an event, all-ones fields and a timer equal to the capture.
	task automatic test_reset_defaults();
		offer_sample(mk_sample(1'b1, 32'd100, 32'd1003, 16'd1000, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b0, 32'd7, 32'd1001, 16'hABCD, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0));
		drain_results();
	endtask

	// Counter wrap at 100 counts per turn: corrected rollovers both ways, wrap
	// flags with the count on the limit, both flags at once, a capture error
	// on an event and without one, and a zero timer difference.
	task automatic test_count_wrap();
		apply_settings(MODE_ROTARY, 32'd99, 32'd42949673, 32'd7, 32'h8000, 32'hFFFF_FFFF);
		offer_sample(mk_sample(1'b1, 32'd90, 32'd102, 16'd100, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd5, 32'd12, 16'd10, 1'b1, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd99, 32'd22, 16'd20, 1'b1, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd0, 32'd33, 16'd30, 1'b0, 1'b1, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd95, 32'd41, 16'd40, 1'b0, 1'b1, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd99, 32'd55, 16'd50, 1'b1, 1'b1, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd3, 32'd61, 16'd60, 1'b1, 1'b1, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd50, 32'd72, 16'd70, 1'b0, 1'b0, 1'b1));
		offer_sample(mk_sample(1'b0, 32'd80, 32'd71, 16'd0, 1'b1, 1'b0, 1'b1));
		offer_sample(mk_sample(1'b1, 32'd60, 32'd90, 16'd80, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b0, 32'd61, 32'd80, 16'd0, 1'b0, 1'b0, 1'b0));
		drain_results();
	endtask

	// Registers outside their useful range: a counter that wraps at one, pole
	// pairs written with a stray upper bit, and zero pole pairs.
	task automatic test_config_extremes();
		apply_settings(MODE_ROTARY, 32'd0, 32'hFFFF_FFFF, 32'hFF, 32'hFFFF, 32'h0001_0000);
		offer_sample(mk_sample(1'b1, 32'd0, 32'd5, 16'd4, 1'b1, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd5, 32'd7, 16'd6, 1'b1, 1'b0, 1'b0));
		drain_results();
		apply_settings(MODE_ROTARY, 32'd4095, 32'h1000_0000, 32'd0, 32'd0, 32'h0001_0000);
		offer_sample(mk_sample(1'b1, 32'd7, 32'd12, 16'd10, 1'b0, 1'b0, 1'b0));
		drain_results();
	endtask

	// Linear mode with full gain: the speed and its differences run into both
	// clamps, then a sample without an event drops the speed to zero.
	task automatic test_linear_mode();
		apply_settings(MODE_LINEAR, 32'hFFFF_FFFF, 32'h8000_0001, 32'd64, 32'h1234,
			32'hFFFF_FFFF);
		offer_sample(mk_sample(1'b1, 32'd0, 32'd10, 16'd1, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'h7FFF_FFFF, 32'd20, 16'd2, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'd0, 32'd30, 16'd3, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b0, 32'd5, 32'd40, 16'd4, 1'b0, 1'b0, 1'b0));
		offer_sample(mk_sample(1'b1, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 1'b1, 1'b0));
		drain_results();
	endtask

	// Random phases, each under its own settings. The first two put most
	// registers at their low and high extremes; every third phase runs with
	// no idling at all.
	task automatic test_random_phases();
		logic [31:0] max_cnt, s_gain;
		for (int k = 0; k < 8; k++) begin
			gaps_on = (k % 3 != 2);
			case ($urandom_range(0, 2))
				0: max_cnt = $urandom_range(1, 5000);
				1: max_cnt = $urandom;
				default: max_cnt = 32'hFFFF_FFFF;
			endcase
			s_gain = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
			case (k)
				0: apply_settings(MODE_ROTARY, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0);
				1: apply_settings(MODE_LINEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd64,
					32'hFFFF, 32'hFFFF_FFFF);
				default: apply_settings(32'(k % 2), max_cnt, $urandom,
					$urandom_range(1, 64), $urandom_range(0, 65535), s_gain);
			endcase
			repeat (45) offer_sample(random_sample());
			drain_results();
		end
	endtask

	// The result side holds off for a long stretch while samples keep being
	// offered, so the output register fills and the sample channel stalls.
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		sink_hold_req = 500;
		repeat (8) offer_sample(random_sample());
		drain_results();
	endtask

	// The sender stops until every owed result is in, then carries on under
	// the same settings.
	task automatic test_pause_and_resume();
		gaps_on = 1'b1;
		repeat (6) offer_sample(random_sample());
		drain_results();
		repeat (6) offer_sample(random_sample());
		drain_results();
	endtask

	// Closing stretch at full rate in both modes, with no idling on either side.
	task automatic test_no_idle();
		gaps_on = 1'b0;
		apply_settings(MODE_ROTARY, 32'd1023, $urandom, 32'd3, $urandom_range(0, 65535),
			32'h00FF_0000);
		repeat (20) offer_sample(random_sample());
		drain_results();
		apply_settings(MODE_LINEAR, 32'd1023, $urandom, 32'd5, $urandom_range(0, 65535),
			$urandom);
		repeat (20) offer_sample(random_sample());
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall bursts, or a long hold when a test asks for one.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (sink_hold_req != 0) begin
			sink_stall    = sink_hold_req;
			sink_hold_req = 0;
		end else if (sink_stall == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
			sink_stall = $urandom_range(1, 17);
		end
		if (sink_stall != 0) begin
			result_ready <= 1'b0;
			sink_stall--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Checking: every accepted result request against the oldest estimate.
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (due_estimates.size() == 0) begin
				$display("%0t ns: result with nothing owed, expected none, got mech_speed %h",
					$time, result.mech_speed);
				mismatch_count++;
			end else begin
				want = due_estimates.pop_front();
				check_field("mech_angle", want.mech_angle, result.mech_angle);
				check_field("elec_angle", want.elec_angle, result.elec_angle);
				check_field("mech_speed", want.mech_speed, result.mech_speed);
				check_field("elec_speed", want.elec_speed, result.elec_speed);
				check_field("accel_diff", want.accel_diff, result.accel_diff);
				check_field("jerk_diff", want.jerk_diff, result.jerk_diff);
				check_field("wrap_errors", want.wrap_errors, result.wrap_errors);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** encoder_angle_speed_estimator: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_count_wrap();
		test_config_extremes();
		test_linear_mode();
		test_random_phases();
		test_output_backpressure();
		test_pause_and_resume();
		test_no_idle();
		// Any stray result during this window is caught by the checker.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_estimates.size() != 0) begin
			$display("%0t ns: %0d results never arrived, expected 0 left, got %0d",
				$time, due_estimates.size(), due_estimates.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("** encoder_angle_speed_estimator: PASSED **");
		end else begin
			$display("** encoder_angle_speed_estimator: FAILED **");
		end
		$finish;
	end

endmodule
